[design/assert_macros.svh]
// assertion macros used by sum_checked_frame_receiver
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication on the block clock
`define SCFR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scfr check failed");

// non-overlapping implication on the block clock
`define SCFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scfr check failed");

`endif

[design/scfr_pkg.sv]
package scfr_pkg;

   typedef logic [1:0] csr_idx_type;

   localparam csr_idx_type CSR_HEADER_BYTE   = 2'd0;
   localparam csr_idx_type CSR_MAX_LENGTH    = 2'd1;
   localparam csr_idx_type CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic [7:0] HEADER_BYTE_RESET   = 8'hFE;
   localparam logic [7:0] MAX_LENGTH_RESET    = 8'd99;
   localparam logic [7:0] TIMEOUT_TICKS_RESET = 8'd10;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BADSUM  = 2'd1;
   localparam logic [1:0] ST_TOOLONG = 2'd2;
   localparam logic [1:0] ST_TIMEOUT = 2'd3;

   localparam logic [7:0] TICK_SATURATE = 8'hFF;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_DATA = 4'b0100,
      PH_SUM  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] header_byte;
      logic [7:0] max_length;
      logic [7:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic       out_kind;
      logic [7:0] payload_byte;
      logic [7:0] byte_offset;
      logic [1:0] frame_status;
      logic [7:0] frame_length;
   } result_type;

endpackage

[design/scfr_req_if.sv]
interface scfr_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink (input valid, input func, input rx_byte, output ready);
endinterface

[design/scfr_rsp_if.sv]
interface scfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_kind;
   logic [7:0] payload_byte;
   logic [7:0] byte_offset;
   logic [1:0] frame_status;
   logic [7:0] frame_length;

   modport source (output valid, output out_kind, output payload_byte, output byte_offset,
                   output frame_status, output frame_length, input ready);
   modport sink (input valid, input out_kind, input payload_byte, input byte_offset,
                 input frame_status, input frame_length, output ready);
endinterface

[design/scfr_csr_if.sv]
interface scfr_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

[design/sum_checked_frame_receiver.sv]
// Length-prefixed frame receiver with an 8-bit additive checksum. Each item on req_if is a
// received byte (func 0) or a timer tick (func 1). The block hunts for the header byte, reads
// a length byte, passes each payload byte out with its offset, and closes the frame with one
// status item on rsp_if (ok, checksum mismatch, length too long or timeout) carrying the
// declared length. A zero length, bytes outside a frame and ticks in idle give no item.
// Oversized frames are read to their end silently and then reported as too long. One item is
// taken every clock cycle unless rsp_if stalls; an item waits in the input register, updates
// the frame state as it leaves, and its result waits in the result register. Registers on
// csr_if (0 header byte, 1 max length, 2 timeout ticks) are to be written by the user only
// while no item is in flight; the block does not enforce this. Writes to index 3 are dropped.
module sum_checked_frame_receiver (
   input  logic      clock,
   input  logic      reset,
   scfr_req_if.sink   req_if,
   scfr_rsp_if.source rsp_if,
   scfr_csr_if.sink   csr_if
);
   import scfr_pkg::*;
   `include "assert_macros.svh"

   cfg_type    cfg;
   result_type res;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic       s1_func_ff;
   logic [7:0] s1_byte_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;

   logic       accept;
   logic       out_free;
   logic       advance;

   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign advance       = s1_valid_ff && out_free;
   assign req_if.ready  = !s1_valid_ff || advance;
   assign accept        = req_if.valid && req_if.ready;

   scfr_csr_regs u_csr_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   scfr_frame_core u_frame_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .func    (s1_func_ff),
      .rx_byte (s1_byte_ff),
      .cfg     (cfg),
      .res     (res)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = res.valid;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff <= req_if.func;
         s1_byte_ff <= req_if.rx_byte;
      end
      if (advance && res.valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_kind     = rsp_data_ff.out_kind;
   assign rsp_if.payload_byte = rsp_data_ff.payload_byte;
   assign rsp_if.byte_offset  = rsp_data_ff.byte_offset;
   assign rsp_if.frame_status = rsp_data_ff.frame_status;
   assign rsp_if.frame_length = rsp_data_ff.frame_length;

   `SCFR_ASSERT_NEXT(a_item_held, s1_valid_ff && !advance, s1_valid_ff)
   `SCFR_ASSERT_NEXT(a_result_shown, advance && res.valid, rsp_valid_ff)
   `SCFR_ASSERT_NOW(a_payload_clean, rsp_valid_ff && rsp_if.out_kind == KIND_PAYLOAD, rsp_if.frame_status == ST_OK && rsp_if.frame_length == 8'd0)

endmodule

[design/scfr_csr_regs.sv]
module scfr_csr_regs (
   input  logic              clock,
   input  logic              reset,
   scfr_csr_if.sink          csr_if,
   output scfr_pkg::cfg_type cfg
);
   import scfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_HEADER_BYTE:   cfg_in.header_byte   = csr_if.wdata;
            CSR_MAX_LENGTH:    cfg_in.max_length    = csr_if.wdata;
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_if.wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte   <= HEADER_BYTE_RESET;
         cfg_ff.max_length    <= MAX_LENGTH_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/scfr_frame_core.sv]
module scfr_frame_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 func,
   input  logic [7:0]           rx_byte,
   input  scfr_pkg::cfg_type    cfg,
   output scfr_pkg::result_type res
);
   import scfr_pkg::*;

   phase_type  phase_ff;
   phase_type  phase_in;
   logic [7:0] exp_len_ff;
   logic [7:0] exp_len_in;
   logic [7:0] seen_ff;
   logic [7:0] seen_in;
   logic [7:0] sum_ff;
   logic [7:0] sum_in;
   logic [7:0] ticks_ff;
   logic [7:0] ticks_in;

   logic [7:0] tick_next;
   logic [7:0] seen_next;
   logic [7:0] sum_next;
   logic       too_long;

   assign tick_next = (ticks_ff == TICK_SATURATE) ? ticks_ff : ticks_ff + 8'd1;
   assign seen_next = seen_ff + 8'd1;
   assign sum_next  = sum_ff + rx_byte;
   assign too_long  = exp_len_ff > cfg.max_length;

   always_comb begin
      phase_in   = phase_ff;
      exp_len_in = exp_len_ff;
      seen_in    = seen_ff;
      sum_in     = sum_ff;
      ticks_in   = ticks_ff;
      res        = '0;
      if (step) begin
         if (func == FUNC_TICK) begin
            if (phase_ff != PH_IDLE) begin
               if (tick_next >= cfg.timeout_ticks) begin
                  phase_in         = PH_IDLE;
                  exp_len_in       = '0;
                  seen_in          = '0;
                  sum_in           = '0;
                  ticks_in         = '0;
                  res.valid        = 1'b1;
                  res.out_kind     = KIND_STATUS;
                  res.frame_status = ST_TIMEOUT;
                  res.frame_length = exp_len_ff;
               end else begin
                  ticks_in = tick_next;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  if (rx_byte == cfg.header_byte) begin
                     phase_in   = PH_LEN;
                     exp_len_in = '0;
                     seen_in    = '0;
                     sum_in     = '0;
                     ticks_in   = '0;
                  end
               end
               PH_LEN: begin
                  if (rx_byte == 8'd0) begin
                     phase_in   = PH_IDLE;
                     exp_len_in = '0;
                     seen_in    = '0;
                     sum_in     = '0;
                     ticks_in   = '0;
                  end else begin
                     phase_in   = PH_DATA;
                     exp_len_in = rx_byte;
                     seen_in    = '0;
                     sum_in     = '0;
                  end
               end
               PH_DATA: begin
                  sum_in  = sum_next;
                  seen_in = seen_next;
                  if (seen_next >= exp_len_ff) begin
                     phase_in = PH_SUM;
                  end
                  if (!too_long) begin
                     res.valid        = 1'b1;
                     res.out_kind     = KIND_PAYLOAD;
                     res.payload_byte = rx_byte;
                     res.byte_offset  = seen_ff;
                  end
               end
               PH_SUM: begin
                  phase_in         = PH_IDLE;
                  exp_len_in       = '0;
                  seen_in          = '0;
                  sum_in           = '0;
                  ticks_in         = '0;
                  res.valid        = 1'b1;
                  res.out_kind     = KIND_STATUS;
                  res.frame_length = exp_len_ff;
                  if (too_long) begin
                     res.frame_status = ST_TOOLONG;
                  end else if (rx_byte == sum_ff) begin
                     res.frame_status = ST_OK;
                  end else begin
                     res.frame_status = ST_BADSUM;
                  end
               end
               default: begin
                  phase_in   = PH_IDLE;
                  exp_len_in = '0;
                  seen_in    = '0;
                  sum_in     = '0;
                  ticks_in   = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         exp_len_ff <= '0;
         seen_ff    <= '0;
         sum_ff     <= '0;
         ticks_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         exp_len_ff <= exp_len_in;
         seen_ff    <= seen_in;
         sum_ff     <= sum_in;
         ticks_ff   <= ticks_in;
      end
   end

endmodule
